/* hw/rtl/tccw_pkg.sv */
// text console cursor writer: shared types, sizes and character codes
// depends on nothing; used by every module of the console core
`timescale 1ns / 1ps

package tccw_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ROW_W         = 5;
    localparam int COL_W         = 7;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int CHAR_W        = 8;
    localparam int CELL_W        = 2 * CHAR_W;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // op field codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOUR   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROMPT_LENGTH = 1'b1;
    localparam logic [CHAR_W-1:0]      TEXT_COLOUR_RESET = 8'd7;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic              from_user;
        logic [COL_W-1:0]  cell_column;
        logic [ROW_W-1:0]  cell_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              command_request;
        logic [ROW_W-1:0]  command_row;
        logic              ignored;
        logic [CHAR_W-1:0] read_char;
        logic [CHAR_W-1:0] read_colour;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_NEWLINE   = 2'd1,
        KIND_BACKSPACE = 2'd2,
        KIND_PRINT     = 2'd3
    } kind_t;

    // classified word as queued for the back end
    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_code;
        logic              from_user;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              in_range;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_colour;
        logic [COL_W-1:0]  prompt_length;
    } cfg_t;

endpackage

/* hw/rtl/tccw_front.sv */
// front end: classifies incoming words into commands for the queue
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  tccw_pkg::in_item_t s_data,
    input  logic               queue_full,
    input  logic               clear_busy,
    output logic               push,
    output tccw_pkg::cmd_t     cmd
);

    // accept only when the queue has room and the buffer is not being cleared
    assign s_ready = !queue_full && !clear_busy;
    assign push    = s_valid && s_ready;

    // classify the word
    always_comb begin
        cmd.char_code = s_data.char_code;
        cmd.from_user = s_data.from_user;
        cmd.col       = s_data.cell_column;
        cmd.row       = s_data.cell_row;
        cmd.in_range  = (s_data.cell_column < tccw_pkg::COL_W'(tccw_pkg::SCREEN_WIDTH))
                     && (s_data.cell_row < tccw_pkg::ROW_W'(tccw_pkg::SCREEN_HEIGHT));
        if (s_data.op == tccw_pkg::OP_READ) begin
            cmd.kind = tccw_pkg::KIND_READ;
        end else if (s_data.char_code == tccw_pkg::CH_NEWLINE) begin
            cmd.kind = tccw_pkg::KIND_NEWLINE;
        end else if (s_data.char_code == tccw_pkg::CH_BACKSPACE) begin
            cmd.kind = tccw_pkg::KIND_BACKSPACE;
        end else begin
            cmd.kind = tccw_pkg::KIND_PRINT;
        end
    end

endmodule

/* hw/rtl/tccw_queue.sv */
// short command queue between front and back end
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tccw_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output tccw_pkg::cmd_t head
);

    tccw_pkg::cmd_t                  entry_reg [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tccw_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tccw_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/tccw_back.sv */
// back end: cursor state, cell buffer, scroll and reset clearing
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tccw_pkg::cfg_t      cfg,
    input  logic                q_not_empty,
    input  tccw_pkg::cmd_t      q_head,
    output logic                q_pop,
    output logic                clear_busy,
    output logic                res_valid,
    input  logic                res_ready,
    output tccw_pkg::out_item_t res
);

    localparam int ROW_W  = tccw_pkg::ROW_W;
    localparam int COL_W  = tccw_pkg::COL_W;
    localparam int ADDR_W = tccw_pkg::ADDR_W;
    localparam int CHAR_W = tccw_pkg::CHAR_W;
    localparam int CELL_W = tccw_pkg::CELL_W;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [COL_W-1:0]    sweep_reg, sweep_next;
    logic [ROW_W-1:0]    base_reg, base_next;
    logic [ROW_W-1:0]    scroll_row_reg, scroll_row_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    tccw_pkg::out_item_t res_reg, res_next;
    logic                rd_hit_reg, rd_hit_next;

    logic [CELL_W-1:0]   mem [tccw_pkg::CELL_COUNT];
    logic [CELL_W-1:0]   mem_q_reg;

    tccw_pkg::cmd_t      cmd;
    logic                is_read;
    logic [ROW_W-1:0]    map_row;
    logic [ROW_W:0]      row_sum;
    logic [ROW_W-1:0]    phys_row;
    logic [ROW_W-1:0]    addr_row;
    logic [COL_W-1:0]    addr_col;
    logic [COL_W-1:0]    wr_col;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic                mem_re;
    logic [CELL_W-1:0]   mem_wdata;
    logic                bs_refused;
    logic [ROW_W-1:0]    nl_row;

    assign cmd        = q_head;
    assign is_read    = (cmd.kind == tccw_pkg::KIND_READ);
    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign clear_busy = (state_reg == ST_CLEAR);

    // backspace refusal inside the prompt and row after a newline
    assign bs_refused = cmd.from_user && (cur_col_reg <= cfg.prompt_length);
    assign nl_row     = (cur_row_reg < ROW_W'(tccw_pkg::SCREEN_HEIGHT - 1))
                      ? cur_row_reg + 1'b1 : cur_row_reg;

    // column written by the current put
    always_comb begin
        if (cmd.kind == tccw_pkg::KIND_BACKSPACE) begin
            wr_col = (cur_col_reg != '0) ? cur_col_reg - 1'b1 : '0;
        end else begin
            wr_col = cur_col_reg;
        end
    end

    // logical row to physical row through the scroll base
    assign map_row  = is_read ? cmd.row : cur_row_reg;
    assign row_sum  = {1'b0, map_row} + {1'b0, base_reg};
    assign phys_row = (row_sum >= (ROW_W + 1)'(tccw_pkg::SCREEN_HEIGHT))
                    ? ROW_W'(row_sum - (ROW_W + 1)'(tccw_pkg::SCREEN_HEIGHT))
                    : ROW_W'(row_sum);

    // cell address
    always_comb begin
        if (state_reg == ST_SCROLL) begin
            addr_row = scroll_row_reg;
            addr_col = sweep_reg;
        end else begin
            addr_row = phys_row;
            addr_col = is_read ? cmd.col : wr_col;
        end
        if (state_reg == ST_CLEAR) begin
            mem_addr = clr_cnt_reg;
        end else begin
            mem_addr = ADDR_W'(addr_row) * ADDR_W'(tccw_pkg::SCREEN_WIDTH)
                     + ADDR_W'(addr_col);
        end
    end

    // main sequencer
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        sweep_next      = sweep_reg;
        base_next       = base_reg;
        scroll_row_next = scroll_row_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        res_next        = res_reg;
        rd_hit_next     = rd_hit_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = {{CHAR_W{1'b0}}, tccw_pkg::CH_SPACE};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(tccw_pkg::CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_not_empty) begin
                    state_next  = ST_DONE;
                    res_next    = '0;
                    rd_hit_next = 1'b0;
                    unique case (cmd.kind)
                        tccw_pkg::KIND_READ: begin
                            mem_re      = cmd.in_range;
                            rd_hit_next = cmd.in_range;
                        end
                        tccw_pkg::KIND_NEWLINE: begin
                            cur_row_next = nl_row;
                            cur_col_next = '0;
                            if (cur_row_reg == ROW_W'(tccw_pkg::SCREEN_HEIGHT - 1)) begin
                                // bottom row: rotate base and blank the old top row
                                scroll_row_next = base_reg;
                                base_next = (base_reg == ROW_W'(tccw_pkg::SCREEN_HEIGHT - 1))
                                          ? '0 : base_reg + 1'b1;
                                sweep_next = '0;
                                state_next = ST_SCROLL;
                            end
                            if (cmd.from_user) begin
                                res_next.command_request = 1'b1;
                                res_next.command_row     = nl_row - 1'b1;
                            end
                        end
                        tccw_pkg::KIND_BACKSPACE: begin
                            if (bs_refused) begin
                                res_next.ignored = 1'b1;
                            end else begin
                                cur_col_next = wr_col;
                                mem_we       = 1'b1;
                            end
                        end
                        tccw_pkg::KIND_PRINT: begin
                            mem_wdata = {cfg.text_colour, cmd.char_code};
                            if (cur_col_reg < COL_W'(tccw_pkg::SCREEN_WIDTH - 1)) begin
                                mem_we = 1'b1;
                            end
                            if (cur_col_reg < COL_W'(tccw_pkg::SCREEN_WIDTH)) begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    res_next.cursor_row    = cur_row_next;
                    res_next.cursor_column = cur_col_next;
                end
            end
            ST_SCROLL: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == COL_W'(tccw_pkg::SCREEN_WIDTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            base_reg    <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            base_reg    <= base_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sweep_reg      <= sweep_next;
        scroll_row_reg <= scroll_row_next;
        res_reg        <= res_next;
        rd_hit_reg     <= rd_hit_next;
    end

    // cell buffer, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    // result word, read data merged in for reads that hit the screen
    assign res_valid = (state_reg == ST_DONE);
    always_comb begin
        res = res_reg;
        if (rd_hit_reg) begin
            res.read_char   = mem_q_reg[CHAR_W-1:0];
            res.read_colour = mem_q_reg[CELL_W-1:CHAR_W];
        end
    end

endmodule

/* hw/rtl/text_console_cursor_writer_core.sv */
// text console cursor writer top level: config registers, output register
// depends on tccw_pkg, tccw_front, tccw_queue, tccw_back
`timescale 1ns / 1ps

//  port group   | direction | carries
//  s_*          | in        | one word: put character or read cell
//  m_*          | out       | one word: cursor, command request, cell read
//  cfg_*        | in        | register write: text colour, prompt length
//
// puts and reads go through the back end as dispatch, then result, which waits for the output register
// a newline on the bottom row also passes through a scroll state that blanks the new bottom row
// after reset the cell buffer is cleared; s_ready is low then
// a two-word queue and the output register let input and output stall apart

module text_console_cursor_writer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tccw_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tccw_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tccw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tccw_pkg::cfg_t      cfg_reg, cfg_next;
    tccw_pkg::cmd_t      push_cmd;
    tccw_pkg::cmd_t      q_head;
    tccw_pkg::out_item_t res;
    tccw_pkg::out_item_t m_data_reg;
    logic                m_valid_reg, m_valid_next;
    logic                push, q_pop, q_full, q_not_empty;
    logic                clear_busy;
    logic                res_valid, res_ready;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            if (cfg_index == tccw_pkg::CFG_TEXT_COLOUR) begin
                cfg_next.text_colour = cfg_wdata;
            end else if (cfg_index == tccw_pkg::CFG_PROMPT_LENGTH) begin
                cfg_next.prompt_length = cfg_wdata[tccw_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_colour   <= tccw_pkg::TEXT_COLOUR_RESET;
            cfg_reg.prompt_length <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tccw_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (q_full),
        .clear_busy (clear_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    tccw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tccw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .clear_busy  (clear_busy),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: takes a word when empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* tb/sv/testbench.sv */
// testbench for the text console cursor writer core: directed table, then random phases
// depends on tccw_pkg and text_console_cursor_writer_core; self-checking against its own console model
`timescale 1ns / 1ps

module testbench;
    import tccw_pkg::*;

    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_WORDS    = 350;
    localparam int DIRECTED_ROWS  = 20;
    localparam logic [CELL_W-1:0] BLANK_CELL = {8'h00, CH_SPACE};

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_word_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // console model state and its register copies
    logic [CELL_W-1:0] screen_cells [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [CHAR_W-1:0] colour_reg;
    int                prompt_reg;

    stim_word_t words_to_send [$];
    out_item_t  pending_results [$];
    stim_word_t word_on_bus;
    out_item_t  want_word;

    int  send_idle_pct = 29;
    int  recv_idle_pct = 77;
    bit  hold_start = 1'b0;
    int  hold_left = 0;
    int  stall_cycles = 0;
    int  fail_count = 0;
    int  words_in = 0;
    int  read_count = 0;
    int  scroll_count = 0;
    int  request_count = 0;
    int  refused_count = 0;

    // op, char, user, read col, read row, typed | row, col, req, cmd row, ignored, char, colour
    int directed_table [DIRECTED_ROWS][13] = '{
        // reads straight after reset: blanks with attribute 0
        '{OP_READ, 0,     0, 0,   0,  1, 0, 0, 0, 0, 0, CH_SPACE, 0},
        '{OP_READ, 8'hFF, 1, 79,  24, 1, 0, 0, 0, 0, 0, CH_SPACE, 0},
        // reads off the screen answer zero
        '{OP_READ, 0,     1, 127, 31, 1, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0,     0, 80,  0,  1, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0,     0, 0,   25, 1, 0, 0, 0, 0, 0, 0, 0},
        // user backspace at column 0 is inside an empty prompt
        '{OP_PUT, CH_BACKSPACE, 1, 0,   0,  1, 0, 0, 0, 0, 1, 0, 0},
        // internal backspace at column 0 stays at column 0
        '{OP_PUT, CH_BACKSPACE, 0, 127, 31, 1, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, 8'h41,        0, 0,   0,  1, 0, 1, 0, 0, 0, 0, 0},
        '{OP_PUT, 8'hFF,        1, 127, 31, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, 8'h00,        0, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0,     0, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 8'hFF, 1, 1,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, CH_BACKSPACE, 1, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0,     0, 2,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        // user newline raises a request for row 0
        '{OP_PUT, CH_NEWLINE,   1, 0,   0,  1, 1, 0, 1, 0, 0, 0, 0},
        '{OP_PUT, CH_NEWLINE,   0, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, 8'h7A,        1, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, CH_BACKSPACE, 0, 0,   0,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0,     0, 0,   2,  0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_PUT, CH_NEWLINE,   1, 127, 31, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    text_console_cursor_writer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // one line per mismatch, printing capped so a broken block stays readable
    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        fail_count++;
        if (fail_count <= 40) begin
            $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                     what, got_v, want_v, words_in);
        end
    endtask

    // console model: one word in, the result word out, state updated
    function automatic out_item_t console_step(in_item_t w);
        out_item_t r;
        int col;
        int row;
        int i;
        r = '0;
        col = int'(w.cell_column);
        row = int'(w.cell_row);
        if (w.op == OP_READ) begin
            read_count++;
            if (col < SCREEN_WIDTH && row < SCREEN_HEIGHT) begin
                r.read_char   = screen_cells[row * SCREEN_WIDTH + col][7:0];
                r.read_colour = screen_cells[row * SCREEN_WIDTH + col][15:8];
            end
        end else if (w.char_code == CH_NEWLINE) begin
            if (cur_row < SCREEN_HEIGHT - 1) begin
                cur_row++;
            end else begin
                // scroll up one row, bottom row blanked
                scroll_count++;
                for (i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++) begin
                    screen_cells[i] = screen_cells[i + SCREEN_WIDTH];
                end
                for (; i < CELL_COUNT; i++) begin
                    screen_cells[i] = BLANK_CELL;
                end
            end
            cur_col = 0;
            if (w.from_user) begin
                request_count++;
                r.command_request = 1'b1;
                r.command_row     = ROW_W'(cur_row - 1);
            end
        end else if (w.char_code == CH_BACKSPACE) begin
            if (w.from_user && cur_col <= prompt_reg) begin
                refused_count++;
                r.ignored = 1'b1;
            end else begin
                if (cur_col > 0) begin
                    cur_col--;
                end
                screen_cells[cur_row * SCREEN_WIDTH + cur_col] = BLANK_CELL;
            end
        end else begin
            // last column never written, column saturates past the end
            if (cur_col < SCREEN_WIDTH - 1) begin
                screen_cells[cur_row * SCREEN_WIDTH + cur_col] = {colour_reg, w.char_code};
            end
            if (cur_col < SCREEN_WIDTH) begin
                cur_col++;
            end
        end
        r.cursor_row    = ROW_W'(cur_row);
        r.cursor_column = COL_W'(cur_col);
        return r;
    endfunction

    function automatic in_item_t put_word(logic [CHAR_W-1:0] ch, logic user);
        in_item_t w;
        w.op          = OP_PUT;
        w.char_code   = ch;
        w.from_user   = user;
        w.cell_column = COL_W'($urandom_range(0, 127));
        w.cell_row    = ROW_W'($urandom_range(0, 31));
        return w;
    endfunction

    function automatic in_item_t read_word(int col, int row);
        in_item_t w;
        w.op          = OP_READ;
        w.char_code   = CHAR_W'($urandom_range(0, 255));
        w.from_user   = 1'($urandom_range(0, 1));
        w.cell_column = COL_W'(col);
        w.cell_row    = ROW_W'(row);
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_printable();
        logic [CHAR_W-1:0] ch;
        do begin
            ch = CHAR_W'($urandom_range(0, 255));
        end while (ch == CH_NEWLINE || ch == CH_BACKSPACE);
        return ch;
    endfunction

    task automatic push_word(input in_item_t w);
        stim_word_t e;
        e.item  = w;
        e.typed = 1'b0;
        e.want  = '0;
        words_to_send.push_back(e);
    endtask

    // random phase: mostly lines of text, edits, reads and newline runs, some noise
    task automatic build_random(input int count);
        int   n;
        int   pick;
        int   len;
        int   k;
        logic user;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            user = 1'($urandom_range(0, 1));
            if (pick < 35) begin
                // a line of output or typed input ended by newline, sometimes past the end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(76, 90) : $urandom_range(0, 24);
                for (k = 0; k < len; k++) begin
                    if (user && $urandom_range(0, 9) == 0) begin
                        push_word(put_word(CH_BACKSPACE, user));
                    end else begin
                        push_word(put_word(pick_printable(), user));
                    end
                end
                push_word(put_word(CH_NEWLINE, user));
                n += len + 1;
            end else if (pick < 50) begin
                // editing around the prompt
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    push_word(put_word(($urandom_range(0, 2) == 0) ? pick_printable() : CH_BACKSPACE,
                                       1'($urandom_range(0, 1))));
                end
                n += len;
            end else if (pick < 75) begin
                // cell reads, a few off the screen
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_word(read_word($urandom_range(0, 127), $urandom_range(0, 31)));
                    end else begin
                        push_word(read_word($urandom_range(0, 79), $urandom_range(0, 24)));
                    end
                end
                n += len;
            end else if (pick < 85) begin
                // run of newlines, at times long enough to reach the bottom and scroll
                len = $urandom_range(1, 26);
                for (k = 0; k < len; k++) begin
                    push_word(put_word(CH_NEWLINE, 1'($urandom_range(0, 1))));
                end
                n += len;
            end else begin
                // noise: any value in every field
                push_word('{op: 1'($urandom_range(0, 1)), char_code: CHAR_W'($urandom_range(0, 255)),
                            from_user: 1'($urandom_range(0, 1)),
                            cell_column: COL_W'($urandom_range(0, 127)),
                            cell_row: ROW_W'($urandom_range(0, 31))});
                n++;
            end
        end
    endtask

    // register writes; call only while the core is idle, which this task does not enforce
    task automatic set_console(input logic [CHAR_W-1:0] colour, input int prompt);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEXT_COLOUR;
        cfg_wdata <= colour;
        @(posedge aclk);
        cfg_index <= CFG_PROMPT_LENGTH;
        cfg_wdata <= CFG_DATA_W'(prompt);
        @(posedge aclk);
        cfg_we <= 1'b0;
        colour_reg = colour;
        prompt_reg = prompt;
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // sender: offer words, predict each accepted one
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            words_in++;
            want_word = console_step(word_on_bus.item);
            if (word_on_bus.typed) begin
                want_word = word_on_bus.want;
            end
            pending_results.push_back(want_word);
        end
        if (aresetn && (!s_valid || s_ready)) begin
            if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                word_on_bus = words_to_send.pop_front();
                s_valid <= 1'b1;
                s_data  <= word_on_bus.item;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: check each result word, stall at random or for a long hold-off
    always @(posedge aclk) begin
        out_item_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none expected", 1, 0);
            end else begin
                exp_w = pending_results.pop_front();
                if (m_data.cursor_row !== exp_w.cursor_row)
                    report_mismatch("cursor_row", int'(m_data.cursor_row), int'(exp_w.cursor_row));
                if (m_data.cursor_column !== exp_w.cursor_column)
                    report_mismatch("cursor_column", int'(m_data.cursor_column),
                                    int'(exp_w.cursor_column));
                if (m_data.command_request !== exp_w.command_request)
                    report_mismatch("command_request", int'(m_data.command_request),
                                    int'(exp_w.command_request));
                if (m_data.command_row !== exp_w.command_row)
                    report_mismatch("command_row", int'(m_data.command_row), int'(exp_w.command_row));
                if (m_data.ignored !== exp_w.ignored)
                    report_mismatch("ignored", int'(m_data.ignored), int'(exp_w.ignored));
                if (m_data.read_char !== exp_w.read_char)
                    report_mismatch("read_char", int'(m_data.read_char), int'(exp_w.read_char));
                if (m_data.read_colour !== exp_w.read_colour)
                    report_mismatch("read_colour", int'(m_data.read_colour), int'(exp_w.read_colour));
            end
        end
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        stim_word_t e;
        int ph;
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_cells[i] = BLANK_CELL;
        end
        cur_row    = 0;
        cur_col    = 0;
        colour_reg = TEXT_COLOUR_RESET;
        prompt_reg = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_console(TEXT_COLOUR_RESET, 0);

        // directed table
        foreach (directed_table[i]) begin
            e.item.op               = 1'(directed_table[i][0]);
            e.item.char_code        = CHAR_W'(directed_table[i][1]);
            e.item.from_user        = 1'(directed_table[i][2]);
            e.item.cell_column      = COL_W'(directed_table[i][3]);
            e.item.cell_row         = ROW_W'(directed_table[i][4]);
            e.typed                 = (directed_table[i][5] != 0);
            e.want.cursor_row       = ROW_W'(directed_table[i][6]);
            e.want.cursor_column    = COL_W'(directed_table[i][7]);
            e.want.command_request  = 1'(directed_table[i][8]);
            e.want.command_row      = ROW_W'(directed_table[i][9]);
            e.want.ignored          = 1'(directed_table[i][10]);
            e.want.read_char        = CHAR_W'(directed_table[i][11]);
            e.want.read_colour      = CHAR_W'(directed_table[i][12]);
            words_to_send.push_back(e);
        end
        wait_drained();

        // random phases, each under its own register setting and idling pattern
        for (ph = 0; ph < 4; ph++) begin
            repeat (4) @(posedge aclk);
            case (ph)
                0: begin
                    set_console(8'hA5, 5);
                    send_idle_pct = 29;
                    recv_idle_pct = 77;
                end
                1: begin
                    set_console(8'hFF, SCREEN_WIDTH);
                    send_idle_pct = 77;
                    recv_idle_pct = 29;
                end
                2: begin
                    set_console(8'h00, 0);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_start    = 1'b1;
                end
                default: begin
                    set_console(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, SCREEN_WIDTH));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            build_random(PHASE_WORDS);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        $display("run covered %0d words: %0d cell reads, %0d scrolls, %0d command requests,",
                 words_in, read_count, scroll_count, request_count);
        $display("%0d refused backspaces, four register settings; %0d mismatches",
                 refused_count, fail_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
